@@ rtl/tbpf_pkg.sv @@
// Shared types, constants and address helpers for the tiled background pixel fetch.
// Used by tbpf_vram, tbpf_pal_ram and tiled_background_pixel_fetch_core.
`timescale 1ns / 1ps

package tbpf_pkg;

    // Default geometry and memory size
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 160;
    localparam int VIDEO_WORDS_DEF   = 32768;

    // Fixed widths set by the field layout
    localparam int VADDR_W     = 16;   // full map / tile halfword address
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_W       = 8;
    localparam int COLOUR_W    = 16;

    // Map entry bit positions
    localparam int HFLIP_BIT = 10;
    localparam int VFLIP_BIT = 11;

    // Request codes
    typedef enum logic [1:0] {
        REQ_VRAM_WRITE = 2'd0,
        REQ_PAL_WRITE  = 2'd1,
        REQ_RENDER     = 2'd2
    } req_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LAYER_CONTROL = 2'd0,
        REG_SCROLL_X      = 2'd1,
        REG_SCROLL_Y      = 2'd2
    } reg_idx_t;

    // What an item in a pipeline stage does
    typedef struct packed {
        logic render;
        logic vram_we;
        logic pal_we;
    } op_t;

    // Map entry address: screen block plus 32x32 position inside it
    function automatic logic [VADDR_W-1:0] map_addr_f(
        input logic [8:0] wx,
        input logic [8:0] wy,
        input logic       wide,
        input logic [4:0] sbase
    );
        logic [1:0] blk;
        logic [5:0] hi;
        blk = wide ? {wy[8], wx[8]} : {1'b0, wy[8]};
        hi  = {1'b0, sbase} + {4'b0, blk};
        return {hi, wy[7:3], wx[7:3]};
    endfunction

    // Tile data address for a flipped pixel position
    function automatic logic [VADDR_W-1:0] tile_addr_f(
        input logic [9:0] tile,
        input logic [2:0] px,
        input logic [2:0] py,
        input logic       bpp8,
        input logic [1:0] cbase
    );
        logic [VADDR_W-1:0] off;
        off = bpp8 ? {1'b0, tile, py, px[2:1]} : {2'b0, tile, py, px[2]};
        return {1'b0, cbase, 13'b0} + off;
    endfunction

    // Expand 5-5-5 colour to 0xFFBBGGRR by bit replication
    function automatic logic [31:0] expand_f(input logic [14:0] c);
        return {8'hFF, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
    endfunction

endpackage

@@ rtl/tiled_background_pixel_fetch_core.sv @@
// Top level of the tiled background pixel fetch: four-stage fetch pipeline.
// Depends on tbpf_pkg, tbpf_vram and tbpf_pal_ram.
//
//  Channel | Signals                                               | Dir
//  --------+-------------------------------------------------------+-----
//  in      | in_valid/in_ready, req_type, mem_address, write_data,  | in
//          | screen_x, screen_y                                    |
//  out     | out_valid/out_ready, pixel_rgbx, opaque, layer_priority| out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data              | in
//
// One item is taken every cycle while no result is held. A rendered pixel
// goes through a map read, a tile read and a palette read, each a registered
// memory port. Writes and off-screen or unused requests give no result.
// A held result (out_valid high, out_ready low) freezes every stage and drops
// in_ready; nothing is lost or repeated. Reset clears valid bits and the
// configuration registers; memories need no clearing pass.
`timescale 1ns / 1ps

module tiled_background_pixel_fetch_core #(
    parameter int SCREEN_WIDTH  = tbpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tbpf_pkg::SCREEN_HEIGHT_DEF,
    parameter int VIDEO_WORDS   = tbpf_pkg::VIDEO_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [14:0] mem_address,
    input  logic [15:0] write_data,
    input  logic [7:0]  screen_x,
    input  logic [7:0]  screen_y,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_rgbx,
    output logic        opaque,
    output logic [1:0]  layer_priority,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tbpf_pkg::*;

    localparam int VA_W = $clog2(VIDEO_WORDS);

    // Configuration registers
    logic [15:0] layer_control_reg;
    logic [8:0]  scroll_x_reg;
    logic [8:0]  scroll_y_reg;

    logic        wide;
    logic        tall;
    logic        bpp8;
    logic        adv;

    // Stage registers
    op_t                 p1_op_reg, p1_op_next;
    logic [VADDR_W-1:0]  p1_addr_reg, p1_addr_next;
    logic [15:0]         p1_data_reg;
    logic [2:0]          p1_px_reg, p1_py_reg;

    op_t                 p2_op_reg;
    logic                p2_oob_reg;
    logic [15:0]         p2_data_reg;
    logic [PAL_W-1:0]    p2_waddr_reg;
    logic [2:0]          p2_px_reg, p2_py_reg;

    op_t                 p3_op_reg;
    logic                p3_oob_reg;
    logic [15:0]         p3_data_reg;
    logic [PAL_W-1:0]    p3_waddr_reg;
    logic [2:0]          p3_px_reg;
    logic [3:0]          p3_bank_reg;

    logic                out_valid_reg;
    logic                opaque_reg;

    // Stage 0 signals
    logic [8:0]          sum_x, sum_y, wx, wy;
    logic                on_screen;
    logic                vram_in_range;
    logic                pal_in_range;

    // Stage 2 signals
    logic [COLOUR_W-1:0] map_rdata, tile_rdata;
    logic [15:0]         entry;
    logic [2:0]          fpx, fpy;
    logic [VADDR_W-1:0]  tile_addr;

    // Stage 3 signals
    logic [15:0]         tile_word;
    logic [7:0]          idx8;
    logic [3:0]          nib;
    logic [PAL_W-1:0]    pal_idx;
    logic                opaque_next;
    logic [COLOUR_W-1:0] pal_rdata;

    assign wide = layer_control_reg[14];
    assign tall = layer_control_reg[15];
    assign bpp8 = layer_control_reg[7];

    // Advance the whole pipeline unless a result is held
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // Accept configuration writes; unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_control_reg <= '0;
            scroll_x_reg      <= '0;
            scroll_y_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LAYER_CONTROL: layer_control_reg <= cfg_data;
                REG_SCROLL_X:      scroll_x_reg      <= cfg_data[8:0];
                REG_SCROLL_Y:      scroll_y_reg      <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // Stage 0: scroll, wrap and locate the map entry; decode and range-check writes
    always_comb
    begin
        sum_x = {1'b0, screen_x} + scroll_x_reg;
        sum_y = {1'b0, screen_y} + scroll_y_reg;
        wx    = {sum_x[8] & wide, sum_x[7:0]};
        wy    = {sum_y[8] & tall, sum_y[7:0]};
        on_screen = ({2'b0, screen_x} < 10'(SCREEN_WIDTH))
                 && ({2'b0, screen_y} < 10'(SCREEN_HEIGHT));
        vram_in_range = {2'b0, mem_address} < 17'(VIDEO_WORDS);
        pal_in_range  = {2'b0, mem_address} < 17'(PAL_ENTRIES);

        p1_op_next   = '0;
        p1_addr_next = {1'b0, mem_address};
        case (req_type)
            REQ_VRAM_WRITE: p1_op_next.vram_we = vram_in_range;
            REQ_PAL_WRITE:  p1_op_next.pal_we  = pal_in_range;
            REQ_RENDER:
            begin
                p1_op_next.render = on_screen;
                p1_addr_next = map_addr_f(wx, wy, wide, layer_control_reg[12:8]);
            end
            default:        p1_op_next = '0;
        endcase
    end

    // Stage 1: video memory write, map entry read
    tbpf_vram #(
        .VIDEO_WORDS (VIDEO_WORDS),
        .ADDR_W      (VA_W)
    ) u_vram (
        .clk     (clk),
        .we      (adv && p1_op_reg.vram_we),
        .waddr   (p1_addr_reg[VA_W-1:0]),
        .wdata   (p1_data_reg),
        .re      (adv),
        .raddr_a (p1_addr_reg[VA_W-1:0]),
        .rdata_a (map_rdata),
        .raddr_b (tile_addr[VA_W-1:0]),
        .rdata_b (tile_rdata)
    );

    // Stage 2: flip and form the tile data address
    always_comb
    begin
        entry     = p2_oob_reg ? 16'h0000 : map_rdata;
        fpx       = entry[HFLIP_BIT] ? ~p2_px_reg : p2_px_reg;
        fpy       = entry[VFLIP_BIT] ? ~p2_py_reg : p2_py_reg;
        tile_addr = tile_addr_f(entry[9:0], fpx, fpy, bpp8, layer_control_reg[3:2]);
    end

    // Stage 3: pick the colour index; palette write and read
    always_comb
    begin
        tile_word = p3_oob_reg ? 16'h0000 : tile_rdata;
        idx8      = p3_px_reg[0] ? tile_word[15:8] : tile_word[7:0];
        nib       = tile_word[{p3_px_reg[1:0], 2'b00} +: 4];
        pal_idx   = bpp8 ? idx8 : {p3_bank_reg, nib};
        opaque_next = bpp8 ? (idx8 != 8'h00) : (nib != 4'h0);
    end

    tbpf_pal_ram u_pal (
        .clk   (clk),
        .we    (adv && p3_op_reg.pal_we),
        .waddr (p3_waddr_reg),
        .wdata (p3_data_reg),
        .re    (adv),
        .raddr (pal_idx),
        .rdata (pal_rdata)
    );

    // Advance the valid bits and operation flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_op_reg     <= '0;
            p2_op_reg     <= '0;
            p3_op_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_op_reg     <= (in_valid && in_ready) ? p1_op_next : '0;
            p2_op_reg     <= p1_op_reg;
            p3_op_reg     <= p2_op_reg;
            out_valid_reg <= p3_op_reg.render;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_addr_reg  <= p1_addr_next;
            p1_data_reg  <= write_data;
            p1_px_reg    <= wx[2:0];
            p1_py_reg    <= wy[2:0];

            p2_oob_reg   <= {1'b0, p1_addr_reg} >= 17'(VIDEO_WORDS);
            p2_data_reg  <= p1_data_reg;
            p2_waddr_reg <= p1_addr_reg[PAL_W-1:0];
            p2_px_reg    <= p1_px_reg;
            p2_py_reg    <= p1_py_reg;

            p3_oob_reg   <= {1'b0, tile_addr} >= 17'(VIDEO_WORDS);
            p3_data_reg  <= p2_data_reg;
            p3_waddr_reg <= p2_waddr_reg;
            p3_px_reg    <= fpx;
            p3_bank_reg  <= entry[15:12];

            opaque_reg   <= opaque_next;
        end
    end

    // Drive the result; transparent pixels carry zero colour
    assign out_valid      = out_valid_reg;
    assign opaque         = opaque_reg;
    assign pixel_rgbx     = opaque_reg ? expand_f(pal_rdata[14:0]) : 32'h0000_0000;
    assign layer_priority = layer_control_reg[1:0];

endmodule

@@ rtl/tbpf_vram.sv @@
// Background video memory: one write port, two registered read ports.
// Depends on tbpf_pkg for the data width.
`timescale 1ns / 1ps

module tbpf_vram #(
    parameter int VIDEO_WORDS = tbpf_pkg::VIDEO_WORDS_DEF,
    parameter int ADDR_W      = $clog2(VIDEO_WORDS)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [tbpf_pkg::COLOUR_W-1:0] wdata,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             raddr_a,
    output logic [tbpf_pkg::COLOUR_W-1:0] rdata_a,
    input  logic [ADDR_W-1:0]             raddr_b,
    output logic [tbpf_pkg::COLOUR_W-1:0] rdata_b
);
    import tbpf_pkg::*;

    logic [COLOUR_W-1:0] mem [VIDEO_WORDS];

    // Write and read in one block: a read at the write address sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ rtl/tbpf_pal_ram.sv @@
// Background palette: 256 halfword entries, one write port, one registered read.
// Depends on tbpf_pkg for sizes.
`timescale 1ns / 1ps

module tbpf_pal_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tbpf_pkg::PAL_W-1:0]    waddr,
    input  logic [tbpf_pkg::COLOUR_W-1:0] wdata,
    input  logic                          re,
    input  logic [tbpf_pkg::PAL_W-1:0]    raddr,
    output logic [tbpf_pkg::COLOUR_W-1:0] rdata
);
    import tbpf_pkg::*;

    logic [COLOUR_W-1:0] mem [PAL_ENTRIES];

    // Write and read in item order; same-edge read returns old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/tbpf_checker.sv @@
// Port-level checks for the tiled background pixel fetch, bound to the top level.
// Depends on tiled_background_pixel_fetch_core.
`timescale 1ns / 1ps

module tbpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_rgbx,
    input logic        opaque
);

    // A held result keeps its payload until the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_rgbx) && $stable(opaque))
        else $error("held result changed before transfer");

    // Transparent pixels carry zero colour
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !opaque |-> pixel_rgbx == 32'h0000_0000)
        else $error("transparent pixel with non-zero colour");

    // Opaque pixels carry full alpha
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opaque |-> pixel_rgbx[31:24] == 8'hFF)
        else $error("opaque pixel without full alpha");

    // Each channel is a replicated 5-bit value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_rgbx[2:0] == pixel_rgbx[7:5]
                   && pixel_rgbx[10:8] == pixel_rgbx[15:13]
                   && pixel_rgbx[18:16] == pixel_rgbx[23:21])
        else $error("colour channel not bit-replicated");

endmodule

bind tiled_background_pixel_fetch_core tbpf_checker u_tbpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_rgbx (pixel_rgbx),
    .opaque     (opaque)
);
